/* design/ckf_pkg.sv */
package ckf_pkg;

    // default and field widths
    localparam int MAX_WIDTH    = 1024;
    localparam int PIX_BITS     = 32;
    localparam int IMG_W_BITS   = 11;
    localparam int IMG_H_BITS   = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int SUM_BITS     = 10;
    localparam int CNT_BITS     = 3;

    // register indexes on the config port
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_KEY_COLOR    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_NONE_COLOR   = 2'd3;

    // register reset values
    localparam logic [IMG_W_BITS-1:0] RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [IMG_H_BITS-1:0] RST_IMAGE_HEIGHT = 16'd1;
    localparam logic [PIX_BITS-1:0]   RST_KEY_COLOR    = 32'd0;
    localparam logic [PIX_BITS-1:0]   RST_NONE_COLOR   = 32'd0;

    // input kind carried on s_tuser
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // reciprocal of three, exact for sums below 1024
    localparam int RECIP3       = 683;
    localparam int RECIP3_SHIFT = 11;

    // truncated mean of one channel over one to four neighbors
    function automatic logic [7:0] mean_chan(input logic [SUM_BITS-1:0] s,
                                             input logic [CNT_BITS-1:0] n);
        logic [2*SUM_BITS:0] prod;
        logic [SUM_BITS-1:0] q;
        prod = (2*SUM_BITS+1)'(s) * (2*SUM_BITS+1)'(RECIP3);
        case (n)
            3'd1: q = s;
            3'd2: q = s >> 1;
            3'd3: q = SUM_BITS'(prod >> RECIP3_SHIFT);
            3'd4: q = s >> 2;
            default: q = '0;
        endcase
        return q[7:0];
    endfunction

endpackage

/* design/color_key_neighbor_fill.sv */
// channel   direction  handshake          payload
// s_        in         s_tvalid/s_tready  s_tdata = pixel_in, s_tuser = func
// m_        out        m_tvalid/m_tready  m_tdata = pixel_out, m_tlast = frame_last
// cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data (ready out of reset)
//
// each item passes memory read, neighbor sums, then mean and write back;
// the read-modify-write of the two row memories keeps one item in flight at a time
// output lags one row; drain items flush the last row, m_tlast on the final pixel
// aresetn is synchronous; it clears counters, config and the output valid
// a result waiting on m_tready stalls the next item at write-back; s_tready stays low until then
// row memories are not cleared by reset
module color_key_neighbor_fill #(
    parameter int MAX_WIDTH = ckf_pkg::MAX_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ckf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ckf_pkg::PIX_BITS-1:0]      cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ckf_pkg::PIX_BITS-1:0]      s_tdata,   // [31:0] pixel_in
    input  logic                              s_tuser,   // [0] func
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ckf_pkg::PIX_BITS-1:0]      m_tdata,   // [31:0] pixel_out
    output logic                              m_tlast    // frame_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = ckf_pkg::PIX_BITS;
    localparam int HW = ckf_pkg::IMG_H_BITS;
    localparam int SW = ckf_pkg::SUM_BITS;
    localparam int NW = ckf_pkg::CNT_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_WRITE
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_FILL,
        ACT_PROC,
        ACT_DRAIN
    } act_t;

    state_t state_reg;
    act_t   act_reg;
    act_t   act_next;

    logic [ckf_pkg::IMG_W_BITS-1:0] image_width_reg;
    logic [HW-1:0]                  image_height_reg;
    logic [PW-1:0]                  key_color_reg;
    logic [PW-1:0]                  none_color_reg;

    logic [AW-1:0] column_count_reg;
    logic [HW-1:0] row_count_reg;
    logic [PW-1:0] left_result_reg;

    // item context captured on the input transfer
    logic [AW-1:0] c_reg;
    logic [HW-1:0] rc_reg;
    logic          hr_reg;
    logic          up_ok_reg;
    logic [PW-1:0] pix_reg;

    // memory read data
    logic [PW-1:0] cur_rd_reg;
    logic [PW-1:0] right_rd_reg;
    logic [PW-1:0] above_rd_reg;

    // neighbor sums
    logic [SW-1:0] sum_r_reg, sum_g_reg, sum_b_reg;
    logic [NW-1:0] n_reg;
    logic          is_key_reg;
    logic [PW-1:0] cur_reg;

    logic [PW-1:0] m_tdata_reg;
    logic          m_tlast_reg;
    logic          m_tvalid_reg;
    logic          m_tvalid_next;

    logic [PW-1:0] above_mem   [MAX_WIDTH];
    logic [PW-1:0] pending_mem [MAX_WIDTH];

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [HW-1:0] rc_eff;
    logic [AW-1:0] c_eff;
    logic [WW-1:0] col_plus1;
    logic          has_right;
    logic          s_fire;
    logic          cfg_fire;

    logic [SW-1:0] sum_r_next, sum_g_next, sum_b_next;
    logic [NW-1:0] n_next;
    logic [PW-1:0] nb_px [4];
    logic          nb_ok [4];

    logic [PW-1:0] res;
    logic          emits;
    logic          wr_go;

    assign cfg_ready = aresetn;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid & s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

    // effective frame size and saturated position
    always_comb begin
        if (image_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(image_width_reg);
        end
        h_eff     = (image_height_reg == '0) ? HW'(1) : image_height_reg;
        rc_eff    = (row_count_reg > h_eff) ? h_eff : row_count_reg;
        c_eff     = (WW'(column_count_reg) >= w_eff) ? AW'(w_eff - WW'(1))
                                                     : column_count_reg;
        col_plus1 = WW'(c_eff) + WW'(1);
        has_right = (col_plus1 < w_eff);
    end

    // classify the incoming item
    always_comb begin
        if (s_tuser == ckf_pkg::FUNC_PIXEL) begin
            if (rc_eff >= h_eff) begin
                act_next = ACT_NONE;
            end else if (rc_eff == '0) begin
                act_next = ACT_FILL;
            end else begin
                act_next = ACT_PROC;
            end
        end else begin
            act_next = (rc_eff < h_eff) ? ACT_NONE : ACT_DRAIN;
        end
    end

    // neighbor sums over left, right, up and down
    always_comb begin
        nb_px[0] = left_result_reg;
        nb_ok[0] = (c_reg != '0);
        nb_px[1] = right_rd_reg;
        nb_ok[1] = hr_reg;
        nb_px[2] = above_rd_reg;
        nb_ok[2] = up_ok_reg;
        nb_px[3] = pix_reg;
        nb_ok[3] = (act_reg == ACT_PROC);
        sum_r_next = '0;
        sum_g_next = '0;
        sum_b_next = '0;
        n_next     = '0;
        for (int i = 0; i < 4; i++) begin
            if (nb_ok[i] && nb_px[i] != key_color_reg) begin
                sum_r_next = sum_r_next + SW'(nb_px[i][23:16]);
                sum_g_next = sum_g_next + SW'(nb_px[i][15:8]);
                sum_b_next = sum_b_next + SW'(nb_px[i][7:0]);
                n_next     = n_next + NW'(1);
            end
        end
    end

    // fill value, write-back enable and output valid
    always_comb begin
        if (!is_key_reg) begin
            res = cur_reg;
        end else if (n_reg == '0) begin
            res = none_color_reg;
        end else begin
            res = {8'h00,
                   ckf_pkg::mean_chan(sum_r_reg, n_reg),
                   ckf_pkg::mean_chan(sum_g_reg, n_reg),
                   ckf_pkg::mean_chan(sum_b_reg, n_reg)};
        end
        emits = (act_reg == ACT_PROC) || (act_reg == ACT_DRAIN);
        wr_go = (state_reg == ST_WRITE) && (!emits || !m_tvalid_reg || m_tready);
        if (wr_go && emits) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // pending row: originals of the row awaiting processing
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cur_rd_reg   <= pending_mem[c_eff];
            right_rd_reg <= pending_mem[AW'(col_plus1)];
        end
        if (wr_go && (act_reg == ACT_FILL || act_reg == ACT_PROC)) begin
            pending_mem[c_reg] <= pix_reg;
        end
    end

    // above row: processed pixels of the previous row
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            above_rd_reg <= above_mem[c_eff];
        end
        if (wr_go && emits) begin
            above_mem[c_reg] <= res;
        end
    end

    // sequencer, counters, config and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            act_reg          <= ACT_NONE;
            image_width_reg  <= ckf_pkg::RST_IMAGE_WIDTH;
            image_height_reg <= ckf_pkg::RST_IMAGE_HEIGHT;
            key_color_reg    <= ckf_pkg::RST_KEY_COLOR;
            none_color_reg   <= ckf_pkg::RST_NONE_COLOR;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            left_result_reg  <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            // config writes
            if (cfg_fire) begin
                case (cfg_index)
                    ckf_pkg::REG_IMAGE_WIDTH:
                        image_width_reg <= cfg_data[ckf_pkg::IMG_W_BITS-1:0];
                    ckf_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[HW-1:0];
                    ckf_pkg::REG_KEY_COLOR:    key_color_reg    <= cfg_data;
                    ckf_pkg::REG_NONE_COLOR:   none_color_reg   <= cfg_data;
                    default: ;
                endcase
            end

            m_tvalid_reg <= m_tvalid_next;

            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        act_reg   <= act_next;
                        c_reg     <= c_eff;
                        rc_reg    <= rc_eff;
                        hr_reg    <= has_right;
                        up_ok_reg <= (s_tuser == ckf_pkg::FUNC_PIXEL)
                                     ? (rc_eff >= HW'(2)) : (h_eff >= HW'(2));
                        pix_reg   <= s_tdata;
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    sum_r_reg  <= sum_r_next;
                    sum_g_reg  <= sum_g_next;
                    sum_b_reg  <= sum_b_next;
                    n_reg      <= n_next;
                    is_key_reg <= (cur_rd_reg == key_color_reg);
                    cur_reg    <= cur_rd_reg;
                    state_reg  <= ST_WRITE;
                end
                ST_WRITE: begin
                    if (wr_go) begin
                        state_reg <= ST_IDLE;
                        case (act_reg)
                            ACT_FILL, ACT_PROC: begin
                                if (!hr_reg) begin
                                    column_count_reg <= '0;
                                    row_count_reg    <= rc_reg + HW'(1);
                                end else begin
                                    column_count_reg <= c_reg + AW'(1);
                                    row_count_reg    <= rc_reg;
                                end
                            end
                            ACT_DRAIN: begin
                                if (!hr_reg) begin
                                    column_count_reg <= '0;
                                    row_count_reg    <= '0;
                                end else begin
                                    column_count_reg <= c_reg + AW'(1);
                                    row_count_reg    <= rc_reg;
                                end
                            end
                            default: ;
                        endcase
                        if (emits) begin
                            left_result_reg <= res;
                            m_tdata_reg     <= res;
                            m_tlast_reg     <= (act_reg == ACT_DRAIN) && !hr_reg;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* design/ckf_checker.sv */
module ckf_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [ckf_pkg::PIX_BITS-1:0]     m_tdata,
    input logic                             m_tlast
);

    // output register is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // one item at a time: no transfer in the cycle after a transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken on back-to-back cycles");

    // a result needs the read and sum cycles before it appears
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after input transfer");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind color_key_neighbor_fill ckf_checker u_ckf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* test/tb_color_key_neighbor_fill.sv */
module tb_color_key_neighbor_fill;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 700;

    typedef struct packed {
        logic                         kind;
        logic [ckf_pkg::PIX_BITS-1:0] pix;
    } pix_item_t;

    typedef struct packed {
        logic [ckf_pkg::PIX_BITS-1:0] pix;
        logic                         last;
    } fill_t;

    logic                             aclk;
    logic                             aresetn   = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [ckf_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [ckf_pkg::PIX_BITS-1:0]     cfg_data  = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [ckf_pkg::PIX_BITS-1:0]     s_tdata   = '0;  // [31:0] pixel_in
    logic                             s_tuser   = 1'b0;  // [0] func
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [ckf_pkg::PIX_BITS-1:0]     m_tdata;  // [31:0] pixel_out
    logic                             m_tlast;  // frame_last

    // pixels waiting to go out, filled pixels waiting to come back
    pix_item_t pixel_stream[$];
    fill_t     due_pixels[$];

    int errors       = 0;
    int quiet_cycles = 0;

    // shadow registers and scan state
    logic [ckf_pkg::IMG_W_BITS-1:0] fill_width      = ckf_pkg::RST_IMAGE_WIDTH;
    logic [ckf_pkg::IMG_H_BITS-1:0] fill_height     = ckf_pkg::RST_IMAGE_HEIGHT;
    logic [ckf_pkg::PIX_BITS-1:0]   fill_key_color  = ckf_pkg::RST_KEY_COLOR;
    logic [ckf_pkg::PIX_BITS-1:0]   fill_none_color = ckf_pkg::RST_NONE_COLOR;
    logic [ckf_pkg::PIX_BITS-1:0]   above_px [ckf_pkg::MAX_WIDTH];
    logic [ckf_pkg::PIX_BITS-1:0]   pend_px  [ckf_pkg::MAX_WIDTH];
    logic [ckf_pkg::PIX_BITS-1:0]   left_px  = '0;
    int                             col_at   = 0;
    int                             row_at   = 0;

    color_key_neighbor_fill DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result for one pixel: itself if not key, else mean of non-key neighbors, alpha cleared, or the none color
    function automatic logic [ckf_pkg::PIX_BITS-1:0] key_mean(
        input logic [ckf_pkg::PIX_BITS-1:0] cur,
        input bit has_l, input logic [ckf_pkg::PIX_BITS-1:0] l,
        input bit has_r, input logic [ckf_pkg::PIX_BITS-1:0] r,
        input bit has_u, input logic [ckf_pkg::PIX_BITS-1:0] u,
        input bit has_d, input logic [ckf_pkg::PIX_BITS-1:0] d);
        logic [ckf_pkg::PIX_BITS-1:0] px [4];
        bit                           use_px [4];
        int                           sum_r, sum_g, sum_b, n;
        if (cur != fill_key_color) return cur;
        px[0] = l;  use_px[0] = has_l;
        px[1] = r;  use_px[1] = has_r;
        px[2] = u;  use_px[2] = has_u;
        px[3] = d;  use_px[3] = has_d;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        n     = 0;
        for (int i = 0; i < 4; i++) begin
            if (use_px[i] && px[i] != fill_key_color) begin
                sum_r += px[i][23:16];
                sum_g += px[i][15:8];
                sum_b += px[i][7:0];
                n++;
            end
        end
        if (n == 0) return fill_none_color;
        return {8'h00, 8'(sum_r / n), 8'(sum_g / n), 8'(sum_b / n)};
    endfunction

    // advance the scan by one accepted item, returns 1 when a pixel comes out
    function automatic bit scan_pixel(input pix_item_t it, output fill_t res);
        int                           w, h, rc, c;
        bit                           has_r;
        logic [ckf_pkg::PIX_BITS-1:0] right;
        w = fill_width;
        if (w == 0) w = 1;
        if (w > ckf_pkg::MAX_WIDTH) w = ckf_pkg::MAX_WIDTH;
        h = fill_height;
        if (h == 0) h = 1;
        rc    = (row_at > h) ? h : row_at;
        c     = (col_at >= w) ? w - 1 : col_at;
        has_r = (c + 1) < w;
        right = has_r ? pend_px[c + 1] : '0;
        res   = '0;
        if (it.kind == ckf_pkg::FUNC_PIXEL) begin
            // all rows in: pixel is dropped
            if (rc >= h) return 0;
            if (rc != 0) begin
                res.pix = key_mean(pend_px[c], c > 0, left_px, has_r, right,
                                   rc >= 2, above_px[c], 1'b1, it.pix);
                above_px[c] = res.pix;
                left_px     = res.pix;
            end
            pend_px[c] = it.pix;
            if (c + 1 >= w) begin
                col_at = 0;
                row_at = rc + 1;
            end else begin
                col_at = c + 1;
                row_at = rc;
            end
            return rc != 0;
        end
        // drain before the frame is complete is dropped
        if (rc < h) return 0;
        res.pix = key_mean(pend_px[c], c > 0, left_px, has_r, right,
                           h >= 2, above_px[c], 1'b0, '0);
        above_px[c] = res.pix;
        left_px     = res.pix;
        if (c + 1 >= w) begin
            res.last = 1'b1;
            col_at   = 0;
            row_at   = 0;
        end else begin
            col_at = c + 1;
            row_at = rc;
        end
        return 1;
    endfunction

    // driver: bursts of transfers with random gaps
    always @(posedge aclk) begin : drive_pixels
        pix_item_t nxt;
        pix_item_t cur;
        fill_t     got;
        int        burst_left;
        int        gap_left;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                cur.kind = s_tuser;
                cur.pix  = s_tdata;
                if (scan_pixel(cur, got)) due_pixels = {due_pixels, got};
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || pixel_stream.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    nxt = pixel_stream.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.pix;
                    s_tuser  <= nxt.kind;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // monitor: check each result transfer, drive the stall pattern
    always @(posedge aclk) begin : watch_results
        fill_t want;
        int    stall_tick;
        int    stall_mode;
        if (!aresetn) begin
            m_tready     <= 1'b0;
            quiet_cycles = 0;
            stall_tick   = 0;
            stall_mode   = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_pixels.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, actual %h last %b",
                             $time, m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = due_pixels.pop_front();
                    if (m_tdata !== want.pix) begin
                        $display("%0t: pixel_out mismatch, expected %h, actual %h",
                                 $time, want.pix, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: frame_last mismatch, expected %b, actual %b",
                                 $time, want.last, m_tlast);
                        errors++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            // receiver stall pattern in one of four random modes
            stall_tick++;
            if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (stall_tick % 4) == 0;
                default: m_tready <= (stall_tick % 11) < 7;
            endcase
        end
    end

    // watchdog on cycles without any transfer
    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(negedge aclk);
        $display("tb_color_key_neighbor_fill: FAIL");
        $finish;
    end

    task automatic write_reg(input logic [ckf_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [31:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            ckf_pkg::REG_IMAGE_WIDTH:  fill_width      = data[ckf_pkg::IMG_W_BITS-1:0];
            ckf_pkg::REG_IMAGE_HEIGHT: fill_height     = data[ckf_pkg::IMG_H_BITS-1:0];
            ckf_pkg::REG_KEY_COLOR:    fill_key_color  = data;
            ckf_pkg::REG_NONE_COLOR:   fill_none_color = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // wait until every filled pixel is back and the pipeline has emptied
    task automatic wait_quiet();
        @(negedge aclk);
        while (pixel_stream.size() != 0 || s_tvalid || due_pixels.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send(input logic kind, input logic [ckf_pkg::PIX_BITS-1:0] pix);
        pix_item_t it;
        it.kind = kind;
        it.pix  = pix;
        pixel_stream = {pixel_stream, it};
    endtask

    // key pixels and near misses make up half, so that fills happen often
    function automatic logic [ckf_pkg::PIX_BITS-1:0] pick_pixel();
        logic [ckf_pkg::PIX_BITS-1:0] p;
        case ($urandom_range(0, 7))
            0, 1, 2: p = fill_key_color;
            3: p = fill_key_color ^ (32'h1 << $urandom_range(0, 31));
            4: p = {$urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00,
                    $urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00};
            default: p = $urandom();
        endcase
        return p;
    endfunction

    // one full frame plus drain, with some dropped items mixed in
    task automatic queue_frame(output int n_sent);
        int w, h;
        w = fill_width;
        if (w == 0) w = 1;
        if (w > ckf_pkg::MAX_WIDTH) w = ckf_pkg::MAX_WIDTH;
        h = (fill_height == 0) ? 1 : fill_height;
        n_sent = 0;
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 24) == 0) send(ckf_pkg::FUNC_DRAIN, $urandom());
            send(ckf_pkg::FUNC_PIXEL, pick_pixel());
            n_sent++;
        end
        if ($urandom_range(0, 3) == 0) send(ckf_pkg::FUNC_PIXEL, $urandom());
        for (int i = 0; i < w; i++) begin
            send(ckf_pkg::FUNC_DRAIN, $urandom());
            n_sent++;
        end
    endtask

    task automatic random_config();
        int   w;
        int   h;
        logic [31:0] c;
        if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 19))
                0:       w = 0;
                1, 2:    w = $urandom_range(9, 48);
                default: w = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 9))
                0:       h = 0;
                1:       h = (w <= 4) ? $urandom_range(9, 20) : 2;
                default: h = $urandom_range(1, 5);
            endcase
            write_reg(ckf_pkg::REG_IMAGE_WIDTH, ($urandom() & ~32'h7FF) | w);
            write_reg(ckf_pkg::REG_IMAGE_HEIGHT, ($urandom() & ~32'hFFFF) | h);
        end
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
                0:       c = 32'h0000_0000;
                1:       c = 32'hFFFF_FFFF;
                default: c = $urandom();
            endcase
            write_reg(ckf_pkg::REG_KEY_COLOR, c);
        end
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
                0:       c = 32'h0000_0000;
                1:       c = 32'hFFFF_FFFF;
                default: c = $urandom();
            endcase
            write_reg(ckf_pkg::REG_NONE_COLOR, c);
        end
    endtask

    initial begin : stimulus
        int n_random;
        int n_frame;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // 3x2 frame, zero key, early drain and a pixel after the last row
        write_reg(ckf_pkg::REG_IMAGE_WIDTH, 32'd3);
        write_reg(ckf_pkg::REG_IMAGE_HEIGHT, 32'd2);
        write_reg(ckf_pkg::REG_KEY_COLOR, 32'h0000_0000);
        write_reg(ckf_pkg::REG_NONE_COLOR, 32'hFFFF_FFFF);
        send(ckf_pkg::FUNC_PIXEL, 32'h0000_0000);
        send(ckf_pkg::FUNC_DRAIN, 32'hFFFF_FFFF);
        send(ckf_pkg::FUNC_PIXEL, 32'h0000_0000);
        send(ckf_pkg::FUNC_PIXEL, 32'hFFFF_FFFF);
        send(ckf_pkg::FUNC_PIXEL, 32'h80FE_FDFC);
        send(ckf_pkg::FUNC_PIXEL, 32'h0000_0000);
        send(ckf_pkg::FUNC_PIXEL, 32'h00FF_FFFF);
        send(ckf_pkg::FUNC_PIXEL, 32'h1234_5678);
        repeat (3) send(ckf_pkg::FUNC_DRAIN, 32'h0000_0000);
        wait_quiet();

        // width and height of zero act as one, lone key pixel gets the none color
        write_reg(ckf_pkg::REG_IMAGE_WIDTH, 32'd0);
        write_reg(ckf_pkg::REG_IMAGE_HEIGHT, 32'd0);
        write_reg(ckf_pkg::REG_KEY_COLOR, 32'hFFFF_FFFF);
        write_reg(ckf_pkg::REG_NONE_COLOR, 32'h0000_0000);
        send(ckf_pkg::FUNC_PIXEL, 32'hFFFF_FFFF);
        send(ckf_pkg::FUNC_DRAIN, 32'h5555_AAAA);
        wait_quiet();

        // tallest frame, then height lowered below the rows already in
        write_reg(ckf_pkg::REG_IMAGE_WIDTH, 32'd1);
        write_reg(ckf_pkg::REG_IMAGE_HEIGHT, 32'h0000_FFFF);
        send(ckf_pkg::FUNC_PIXEL, 32'hFFFF_FFFF);
        send(ckf_pkg::FUNC_PIXEL, 32'h0000_0000);
        send(ckf_pkg::FUNC_PIXEL, 32'hFFFF_FFFF);
        wait_quiet();
        write_reg(ckf_pkg::REG_IMAGE_HEIGHT, 32'd2);
        send(ckf_pkg::FUNC_DRAIN, 32'h0000_0000);
        wait_quiet();

        // width over the maximum, then narrowed mid row so the column saturates
        write_reg(ckf_pkg::REG_KEY_COLOR, 32'h5A5A_5A5A);
        write_reg(ckf_pkg::REG_NONE_COLOR, 32'h1234_5678);
        write_reg(ckf_pkg::REG_IMAGE_WIDTH, 32'hFFFF_F7FF);
        write_reg(ckf_pkg::REG_IMAGE_HEIGHT, 32'd1);
        send(ckf_pkg::FUNC_PIXEL, 32'h5A5A_5A5A);
        send(ckf_pkg::FUNC_PIXEL, 32'h5A5A_5A5B);
        send(ckf_pkg::FUNC_PIXEL, 32'h5A5A_5A5A);
        wait_quiet();
        write_reg(ckf_pkg::REG_IMAGE_WIDTH, 32'd2);
        send(ckf_pkg::FUNC_PIXEL, 32'h5A5A_5A5A);
        send(ckf_pkg::FUNC_DRAIN, 32'h0000_0000);
        send(ckf_pkg::FUNC_DRAIN, 32'h0000_0000);

        // random frames, settings changed between frames while idle
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1) == 0) begin
                wait_quiet();
                random_config();
            end
            queue_frame(n_frame);
            n_random += n_frame;
        end

        wait_quiet();
        if (errors == 0) begin
            $display("tb_color_key_neighbor_fill: PASS");
        end else begin
            $display("tb_color_key_neighbor_fill: FAIL");
        end
        $finish;
    end

endmodule
